// File: rtl/hbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared codes, widths and the controller to datapath command bundle of the
// height grid sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_GRID_SIDE = 1'b0;
  localparam logic REG_VERT_TERM = 1'b1;

  localparam int CoordW  = 17;
  localparam int HeightW = 24;
  localparam int NormW   = 16;
  localparam int IndexW  = 16;
  localparam int CfgW    = 16;
  localparam int SideW   = 9;
  localparam int CntW    = 5;

  localparam logic [SideW-1:0] GRID_SIDE_RST = 9'd256;
  localparam logic [CfgW-1:0]  VERT_TERM_RST = 16'd512;

  typedef struct packed {
    logic            load;
    logic            rd_en;
    logic [CntW-1:0] rd_cnt;
    logic            sq_en;
    logic [1:0]      sq_phase;
    logic            rt_en;
    logic            rt_first;
    logic            dv_en;
    logic            dv_first;
    logic            out_load;
  } hbs_cmd_t;

endpackage

// File: rtl/heightmap_bilinear_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_top
// Height grid with bilinear height lookup and a normalised central
// difference normal.
//
//   channel  | signals                                  | handshake
//   ---------+------------------------------------------+---------------------
//   request  | command_i cell_index_i cell_height_i     | start & !busy
//            | x_coord_i z_coord_i                      |
//   result   | height_o normal_x_o normal_y_o normal_z_o | done_o, one cycle
//   config   | cfg_index_i cfg_data_i                   | cfg_valid_i & ready
//
// a write request is taken and busy stays low
// a sample request keeps busy high from grid fetch to the output state, its
// result strobe comes in the cycle after, and a new request waits until busy
// is low again; its length comes from 20 grid reads on the single read port,
// 32 square root steps at one bit per cycle and 16 shared division steps
// reset leaves the grid contents unknown and needs no clearing pass
// the receiver cannot stall, results are held until the next sample ends
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_top #(
  parameter int MAX_SIDE = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command_i,
  input  logic [hbs_pkg::IndexW-1:0]         cell_index_i,
  input  logic signed [hbs_pkg::HeightW-1:0] cell_height_i,
  input  logic signed [hbs_pkg::CoordW-1:0]  x_coord_i,
  input  logic signed [hbs_pkg::CoordW-1:0]  z_coord_i,
  output logic                               done_o,
  output logic signed [hbs_pkg::HeightW-1:0] height_o,
  output logic signed [hbs_pkg::NormW-1:0]   normal_x_o,
  output logic signed [hbs_pkg::NormW-1:0]   normal_y_o,
  output logic signed [hbs_pkg::NormW-1:0]   normal_z_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [hbs_pkg::CfgW-1:0]           cfg_data_i
);
  import hbs_pkg::*;

  hbs_cmd_t cmd;
  logic     req_take;
  logic     busy_int;

  assign req_take    = start && !busy_int;
  assign cfg_ready_o = 1'b1;
  assign busy        = busy_int;

  hbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (req_take),
    .sample_i (command_i == CMD_SAMPLE),
    .busy_o   (busy_int),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  hbs_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .wr_en_i       (req_take && (command_i == CMD_WRITE)),
    .cell_index_i  (cell_index_i),
    .cell_height_i (cell_height_i),
    .x_coord_i     (x_coord_i),
    .z_coord_i     (z_coord_i),
    .height_o      (height_o),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o)
  );

endmodule

// File: rtl/hbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_ctrl
// Sequencer for one sample request: grid fetch, squares, square root,
// division and result strobe.
// ----------------------------------------------------------------------------
module hbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             sample_i,
  output logic             busy_o,
  output logic             done_o,
  output hbs_pkg::hbs_cmd_t cmd_o
);
  import hbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_DRAIN, S_SQUARE, S_ROOT, S_DIVIDE, S_OUT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [CntW-1:0] cnt_lim;
  logic            cnt_last;

  always_comb begin
    unique case (state_q)
      S_FETCH:  cnt_lim = 5'd19;
      S_DRAIN:  cnt_lim = 5'd1;
      S_SQUARE: cnt_lim = 5'd3;
      S_ROOT:   cnt_lim = 5'd31;
      S_DIVIDE: cnt_lim = 5'd15;
      default:  cnt_lim = '0;
    endcase
  end

  assign cnt_last = (cnt_q == cnt_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (start_i && sample_i) begin
            state_q <= S_FETCH;
          end
        end
        S_FETCH, S_DRAIN, S_SQUARE, S_ROOT, S_DIVIDE: begin
          if (cnt_last) begin
            cnt_q <= '0;
            unique case (state_q)
              S_FETCH:  state_q <= S_DRAIN;
              S_DRAIN:  state_q <= S_SQUARE;
              S_SQUARE: state_q <= S_ROOT;
              S_ROOT:   state_q <= S_DIVIDE;
              default:  state_q <= S_OUT;
            endcase
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && start_i && sample_i;
    cmd_o.rd_en    = (state_q == S_FETCH);
    cmd_o.rd_cnt   = cnt_q;
    cmd_o.sq_en    = (state_q == S_SQUARE);
    cmd_o.sq_phase = cnt_q[1:0];
    cmd_o.rt_en    = (state_q == S_ROOT);
    cmd_o.rt_first = (cnt_q == '0);
    cmd_o.dv_en    = (state_q == S_DIVIDE);
    cmd_o.dv_first = (cnt_q == '0);
    cmd_o.out_load = (state_q == S_OUT);
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: rtl/hbs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_dp
// Datapath: configuration registers, height grid, bilinear fetch pipeline,
// squared length, bitwise square root and three shared-step dividers.
// ----------------------------------------------------------------------------
module hbs_dp #(
  parameter int MAX_SIDE = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hbs_pkg::hbs_cmd_t                  cmd_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [hbs_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                               wr_en_i,
  input  logic [hbs_pkg::IndexW-1:0]         cell_index_i,
  input  logic signed [hbs_pkg::HeightW-1:0] cell_height_i,
  input  logic signed [hbs_pkg::CoordW-1:0]  x_coord_i,
  input  logic signed [hbs_pkg::CoordW-1:0]  z_coord_i,
  output logic signed [hbs_pkg::HeightW-1:0] height_o,
  output logic signed [hbs_pkg::NormW-1:0]   normal_x_o,
  output logic signed [hbs_pkg::NormW-1:0]   normal_y_o,
  output logic signed [hbs_pkg::NormW-1:0]   normal_z_o
);
  import hbs_pkg::*;

  localparam int Depth = MAX_SIDE * MAX_SIDE;
  localparam int AddrW = $clog2(Depth);

  logic [SideW-1:0] grid_side_q;
  logic [CfgW-1:0]  vert_q;
  logic [SideW-1:0] side;
  logic [SideW-1:0] side_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RST;
      vert_q      <= VERT_TERM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_SIDE: grid_side_q <= cfg_data_i[SideW-1:0];
        REG_VERT_TERM: vert_q      <= cfg_data_i;
        default:       vert_q      <= vert_q;
      endcase
    end
  end

  always_comb begin
    side = grid_side_q;
    if (grid_side_q == '0) begin
      side = 9'd1;
    end else if (int'(grid_side_q) > MAX_SIDE) begin
      side = SideW'(MAX_SIDE);
    end
  end

  assign side_m1 = side - 9'd1;

  // sample point
  logic signed [CoordW-1:0] x_q, z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_coord_i;
      z_q <= z_coord_i;
    end
  end

  // fetch stage: point and corner to address and weight
  logic [2:0]         pt0;
  logic [1:0]         cn0;
  logic signed [17:0] xoff, zoff, xo, zo;
  logic [16:0]        xc, zc;
  logic [8:0]         ix, iz, x0, x1, z0, z1, xs, zs, wx, wz;
  logic [9:0]         ix1, iz1;
  logic [17:0]        lin, w0;
  logic [AddrW-1:0]   raddr;

  assign pt0 = cmd_i.rd_cnt[4:2];
  assign cn0 = cmd_i.rd_cnt[1:0];

  always_comb begin
    xoff = '0;
    zoff = '0;
    case (pt0)
      3'd1:    xoff = -18'sd256;
      3'd2:    xoff = 18'sd256;
      3'd3:    zoff = -18'sd256;
      3'd4:    zoff = 18'sd256;
      default: xoff = '0;
    endcase
  end

  always_comb begin
    xo  = 18'(x_q) + xoff;
    zo  = 18'(z_q) + zoff;
    xc  = xo[17] ? '0 : xo[16:0];
    zc  = zo[17] ? '0 : zo[16:0];
    ix  = xc[16:8];
    iz  = zc[16:8];
    ix1 = {1'b0, ix} + 10'd1;
    iz1 = {1'b0, iz} + 10'd1;
    x0  = (ix > side_m1) ? side_m1 : ix;
    z0  = (iz > side_m1) ? side_m1 : iz;
    x1  = (ix1 > {1'b0, side_m1}) ? side_m1 : ix1[8:0];
    z1  = (iz1 > {1'b0, side_m1}) ? side_m1 : iz1[8:0];
    xs  = cn0[0] ? x1 : x0;
    zs  = cn0[1] ? z1 : z0;
    wx  = cn0[0] ? {1'b0, xc[7:0]} : 9'd256 - {1'b0, xc[7:0]};
    wz  = cn0[1] ? {1'b0, zc[7:0]} : 9'd256 - {1'b0, zc[7:0]};
    lin = 18'(zs) * 18'(side) + 18'(xs);
    w0  = 18'(wx) * 18'(wz);
  end

  assign raddr = AddrW'(lin);

  logic [HeightW-1:0] ram_rdata;
  logic               ram_we;

  assign ram_we = wr_en_i && (32'(cell_index_i) < Depth);

  hbs_ram #(
    .Width (HeightW),
    .Depth (Depth)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(cell_index_i)),
    .wdata_i (cell_height_i),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // weight stage and accumulate stage
  logic               v1_q, v2_q;
  logic [2:0]         pt1_q, pt2_q;
  logic [1:0]         cn1_q, cn2_q;
  logic [16:0]        w1_q;
  logic signed [41:0] prod, p2_q, acc_q, acc_sum, acc_rnd;
  logic signed [HeightW-1:0] hpt_q [5];

  assign prod    = 42'($signed(ram_rdata)) * 42'($signed({1'b0, w1_q}));
  assign acc_sum = ((cn2_q == 2'd0) ? 42'sd0 : acc_q) + p2_q;
  assign acc_rnd = acc_sum + 42'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pt1_q <= pt0;
    cn1_q <= cn0;
    w1_q  <= w0[16:0];
    pt2_q <= pt1_q;
    cn2_q <= cn1_q;
    p2_q  <= prod;
    if (v2_q) begin
      acc_q <= acc_sum;
      if (cn2_q == 2'd3) begin
        hpt_q[pt2_q] <= acc_rnd[39:16];
      end
    end
  end

  // squared length
  logic signed [24:0] vx, vy, vz, sq_op;
  logic [49:0]        sqp_q;
  logic [50:0]        s_q;
  logic signed [49:0] sq_full;

  assign vx = 25'(hpt_q[1]) - 25'(hpt_q[2]);
  assign vz = 25'(hpt_q[3]) - 25'(hpt_q[4]);
  assign vy = 25'($signed({1'b0, vert_q}));

  always_comb begin
    case (cmd_i.sq_phase)
      2'd0:    sq_op = vx;
      2'd1:    sq_op = vz;
      default: sq_op = vy;
    endcase
  end

  assign sq_full = 50'(sq_op) * 50'(sq_op);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sqp_q <= sq_full;
      s_q   <= (cmd_i.sq_phase == 2'd0) ? '0 : s_q + 51'(sqp_q);
    end
  end

  // square root, one result bit per cycle
  logic [63:0] rn_q, res_q, bit_q;
  logic [63:0] rn_cur, res_cur, bit_cur, trial;

  assign rn_cur  = cmd_i.rt_first ? {1'b0, s_q, 12'b0} : rn_q;
  assign res_cur = cmd_i.rt_first ? '0 : res_q;
  assign bit_cur = cmd_i.rt_first ? 64'h4000_0000_0000_0000 : bit_q;
  assign trial   = res_cur + bit_cur;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rt_en) begin
      bit_q <= bit_cur >> 2;
      if (rn_cur >= trial) begin
        rn_q  <= rn_cur - trial;
        res_q <= (res_cur >> 1) + bit_cur;
      end else begin
        rn_q  <= rn_cur;
        res_q <= res_cur >> 1;
      end
    end
  end

  // three dividers sharing one divisor
  logic [31:0]        root;
  logic signed [24:0] comp [3];
  logic [24:0]        mag [3];
  logic [47:0]        dn_q [3];
  logic [47:0]        dn_cur [3];
  logic [15:0]        dq_q [3];
  logic [47:0]        dd_q, dd_cur;

  assign root    = res_q[31:0];
  assign comp[0] = vx;
  assign comp[1] = vy;
  assign comp[2] = vz;
  assign dd_cur  = cmd_i.dv_first ? {root, 16'b0} : dd_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]    = comp[i][24] ? 25'(-comp[i]) : 25'(comp[i]);
      dn_cur[i] = cmd_i.dv_first ? 48'({mag[i], 21'b0}) + 48'(root) : dn_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dv_en) begin
      dd_q <= dd_cur >> 1;
      for (int i = 0; i < 3; i++) begin
        if (dn_cur[i] >= dd_cur) begin
          dn_q[i] <= dn_cur[i] - dd_cur;
          dq_q[i] <= {dq_q[i][14:0], 1'b1};
        end else begin
          dn_q[i] <= dn_cur[i];
          dq_q[i] <= {dq_q[i][14:0], 1'b0};
        end
      end
    end
  end

  // result registers
  logic signed [NormW-1:0]   nrm [3];
  logic signed [HeightW-1:0] height_q;
  logic signed [NormW-1:0]   nx_q, ny_q, nz_q;
  logic                      zero_len;

  assign zero_len = (root == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = comp[i][24] ? 16'(16'd0 - dq_q[i]) : dq_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      height_q <= hpt_q[0];
      nx_q     <= zero_len ? 16'sd0 : nrm[0];
      ny_q     <= zero_len ? 16'sd16384 : nrm[1];
      nz_q     <= zero_len ? 16'sd0 : nrm[2];
    end
  end

  assign height_o   = height_q;
  assign normal_x_o = nx_q;
  assign normal_y_o = ny_q;
  assign normal_z_o = nz_q;

endmodule

// File: rtl/hbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_checker
// Port level checks of request and result sequencing.
// ----------------------------------------------------------------------------
module hbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic command_i,
  input logic done_o
);
  import hbs_pkg::*;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_busy_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (command_i == CMD_SAMPLE)))
    else $error("busy without an accepted sample request");

  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("sample finished without a result");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_hbs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .command_i (command_i),
  .done_o    (done_o)
);

// File: tb/tb_heightmap_bilinear_sampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_bilinear_sampler_top
// Self-checking bench for the height grid sampler. Requests are queued by a
// phase sequencer and issued in random bursts. Each accepted request updates
// a bit-true grid predictor. Each result strobe is checked field by field
// against the oldest predicted height and normal. The bench steps through
// several grid side and vertical term settings, extremes included.
// ----------------------------------------------------------------------------
module tb_heightmap_bilinear_sampler_top;
  import hbs_pkg::*;

  typedef struct {
    logic                cmd;
    logic [IndexW-1:0]   idx;
    logic [HeightW-1:0]  hgt;
    logic [CoordW-1:0]   xc;
    logic [CoordW-1:0]   zc;
  } req_t;

  typedef struct {
    logic [HeightW-1:0] h;
    logic [NormW-1:0]   nx;
    logic [NormW-1:0]   ny;
    logic [NormW-1:0]   nz;
  } sample_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 command_i;
  logic [IndexW-1:0]    cell_index_i;
  logic [HeightW-1:0]   cell_height_i;
  logic [CoordW-1:0]    x_coord_i;
  logic [CoordW-1:0]    z_coord_i;
  logic                 done_o;
  logic [HeightW-1:0]   height_o;
  logic [NormW-1:0]     normal_x_o;
  logic [NormW-1:0]     normal_y_o;
  logic [NormW-1:0]     normal_z_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_index_i;
  logic [CfgW-1:0]      cfg_data_i;

  req_t    pending_q[$];
  sample_t samples_due_q[$];
  int      mismatch_cnt;

  // predictor state
  logic signed [HeightW-1:0] grid_mem [65536];
  logic [SideW-1:0]          side_reg;
  logic [CfgW-1:0]           vterm_reg;

  // cells already written, as known when requests are generated
  bit written [65536];
  int gen_side;

  heightmap_bilinear_sampler_top dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .cell_index_i, .cell_height_i,
    .x_coord_i, .z_coord_i, .done_o, .height_o, .normal_x_o, .normal_y_o,
    .normal_z_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int used_side(logic [SideW-1:0] s);
    if (s < 1) return 1;
    if (s > 256) return 256;
    return int'(s);
  endfunction

  function automatic longint grid_lerp(longint x, longint z);
    int sd;
    longint ix, iz, fx, fz, x0, x1, z0, z1, acc;
    sd = used_side(side_reg);
    if (x < 0) x = 0;
    if (z < 0) z = 0;
    ix = x >>> 8;
    iz = z >>> 8;
    fx = x & 255;
    fz = z & 255;
    x0 = (ix > sd - 1) ? sd - 1 : ix;
    x1 = (ix + 1 > sd - 1) ? sd - 1 : ix + 1;
    z0 = (iz > sd - 1) ? sd - 1 : iz;
    z1 = (iz + 1 > sd - 1) ? sd - 1 : iz + 1;
    acc = longint'(grid_mem[z0 * sd + x0]) * (256 - fx) * (256 - fz)
        + longint'(grid_mem[z0 * sd + x1]) * fx * (256 - fz)
        + longint'(grid_mem[z1 * sd + x0]) * (256 - fx) * fz
        + longint'(grid_mem[z1 * sd + x1]) * fx * fz;
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [NormW-1:0] unit_comp(longint c, longint unsigned r);
    longint unsigned a, q;
    a = (c < 0) ? longint'(-c) : c;
    q = ((a << 21) + r) / (2 * r);
    return (c < 0) ? NormW'(-longint'(q)) : NormW'(q);
  endfunction

  function automatic sample_t predict_sample(longint x, longint z);
    sample_t res;
    longint vx, vy, vz;
    longint unsigned sq, r;
    res.h = HeightW'(grid_lerp(x, z));
    vx = grid_lerp(x - 256, z) - grid_lerp(x + 256, z);
    vz = grid_lerp(x, z - 256) - grid_lerp(x, z + 256);
    vy = vterm_reg;
    sq = vx * vx + vy * vy + vz * vz;
    r = root_floor(sq << 12);
    if (r == 0) begin
      res.nx = '0;
      res.ny = NormW'(16384);
      res.nz = '0;
    end else begin
      res.nx = unit_comp(vx, r);
      res.ny = unit_comp(vy, r);
      res.nz = unit_comp(vz, r);
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // driver: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_q.size() > 0) begin
      start         <= 1'b1;
      command_i     <= pending_q[0].cmd;
      cell_index_i  <= pending_q[0].idx;
      cell_height_i <= pending_q[0].hgt;
      x_coord_i     <= pending_q[0].xc;
      z_coord_i     <= pending_q[0].zc;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom % 4 == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
        gap_left = ($urandom % 5 == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // request acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      req_t rq;
      rq = pending_q.pop_front();
      if (rq.cmd == CMD_WRITE) begin
        grid_mem[rq.idx] = rq.hgt;
      end else begin
        samples_due_q.push_back(predict_sample(longint'($signed(rq.xc)),
                                               longint'($signed(rq.zc))));
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (samples_due_q.size() == 0) begin
        report("unexpected result", height_o, 0);
      end else begin
        sample_t ex;
        ex = samples_due_q.pop_front();
        if (height_o !== ex.h) report("height", height_o, ex.h);
        if (normal_x_o !== ex.nx) report("normal_x", normal_x_o, ex.nx);
        if (normal_y_o !== ex.ny) report("normal_y", normal_y_o, ex.ny);
        if (normal_z_o !== ex.nz) report("normal_z", normal_z_o, ex.nz);
      end
    end
  end

  task automatic push_write(int idx, logic [HeightW-1:0] hgt);
    req_t rq;
    rq.cmd = CMD_WRITE;
    rq.idx = IndexW'(idx);
    rq.hgt = hgt;
    rq.xc  = CoordW'($urandom);
    rq.zc  = CoordW'($urandom);
    written[idx & 16'hffff] = 1'b1;
    pending_q.push_back(rq);
  endtask

  task automatic push_sample(int x, int z);
    req_t rq;
    rq.cmd = CMD_SAMPLE;
    rq.idx = IndexW'($urandom);
    rq.hgt = HeightW'($urandom);
    rq.xc  = CoordW'(x);
    rq.zc  = CoordW'(z);
    pending_q.push_back(rq);
  endtask

  // every cell that any of the five lookups of a sample may touch
  function automatic bit cells_known(int x, int z);
    int xl, xh, zl, zh;
    xl = (x - 256 < 0) ? 0 : (x - 256) >>> 8;
    xh = ((x + 256 < 0) ? 0 : (x + 256) >>> 8) + 1;
    zl = (z - 256 < 0) ? 0 : (z - 256) >>> 8;
    zh = ((z + 256 < 0) ? 0 : (z + 256) >>> 8) + 1;
    if (xl > gen_side - 1) xl = gen_side - 1;
    if (xh > gen_side - 1) xh = gen_side - 1;
    if (zl > gen_side - 1) zl = gen_side - 1;
    if (zh > gen_side - 1) zh = gen_side - 1;
    for (int r = zl; r <= zh; r++)
      for (int c = xl; c <= xh; c++)
        if (!written[r * gen_side + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_coord();
    int hi;
    hi = gen_side * 256 + 300;
    if (hi > 65535) hi = 65535;
    case ($urandom % 4)
      0:       return int'($signed(CoordW'($urandom)));
      1:       return $urandom_range(0, 1100) - 300;
      2:       return $urandom_range((gen_side - 3) * 256, 65535);
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic fill_grid();
    if (gen_side <= 8) begin
      for (int i = 0; i < gen_side * gen_side; i++) push_write(i, HeightW'($urandom));
    end else begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          push_write(r * gen_side + c, HeightW'($urandom));
          push_write(r * gen_side + gen_side - 4 + c, HeightW'($urandom));
          push_write((gen_side - 4 + r) * gen_side + c, HeightW'($urandom));
          push_write((gen_side - 4 + r) * gen_side + gen_side - 4 + c, HeightW'($urandom));
        end
    end
  endtask

  task automatic random_traffic(int n);
    int x, z, tries;
    for (int i = 0; i < n; i++) begin
      if ($urandom % 5 == 0) begin
        push_write($urandom_range(0, 65535), HeightW'($urandom));
      end else begin
        tries = 0;
        do begin
          x = pick_coord();
          z = pick_coord();
          tries++;
        end while (!cells_known(x, z) && tries < 30);
        if (!cells_known(x, z)) begin
          x = 0;
          z = 0;
        end
        push_sample(x, z);
      end
    end
  endtask

  task automatic settle();
    while (pending_q.size() > 0 || samples_due_q.size() > 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_GRID_SIDE) side_reg = data[SideW-1:0];
    else vterm_reg = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [SideW-1:0] sd, logic [CfgW-1:0] vt, int n);
    settle();
    cfg_write(REG_GRID_SIDE, {7'($urandom_range(0, 127)), sd});
    cfg_write(REG_VERT_TERM, vt);
    gen_side = used_side(sd);
    fill_grid();
    random_traffic(n);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = CMD_WRITE;
    cell_index_i  = '0;
    cell_height_i = '0;
    x_coord_i     = '0;
    z_coord_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_GRID_SIDE;
    cfg_data_i    = '0;
    mismatch_cnt  = 0;
    side_reg      = GRID_SIDE_RST;
    vterm_reg     = VERT_TERM_RST;
    gen_side      = 256;
    for (int i = 0; i < 65536; i++) grid_mem[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme heights side by side, corners, clamping coordinates
    fill_grid();
    push_write(0, 24'h7fffff);
    push_write(1, 24'h800000);
    push_write(256, 24'h000000);
    push_write(257, 24'h7fffff);
    push_write(65535, 24'h800000);
    push_write(65534, 24'h7fffff);
    push_sample(0, 0);
    push_sample(-65536, -65536);
    push_sample(65535, 65535);
    push_sample(65535, 0);
    push_sample(0, 65535);
    push_sample(255, 255);
    push_sample(128, 1);
    push_sample(-1, 300);
    push_sample(65280, 65407);
    random_traffic(60);

    run_phase(9'd4, 16'd1, 120);
    run_phase(9'd2, 16'd65535, 120);
    run_phase(9'd0, 16'd0, 60);
    run_phase(9'd511, 16'd300, 120);
    run_phase(9'd7, 16'($urandom), 120);
    run_phase(9'd100, 16'($urandom), 120);
    run_phase(9'd3, 16'd0, 80);
    run_phase(9'd256, 16'($urandom_range(1, 65535)), 120);

    while (pending_q.size() > 0 || samples_due_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && samples_due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
